FILE: rtl/itrd_pkg.sv
// Package for the integer to radix digits core.
// Holds field widths, digit constants and the digit to ASCII mapping.
// No dependencies.
package itrd_pkg;

    localparam int RADIX_W            = 6;
    localparam int VALUE_W            = 31;
    localparam int CHAR_W             = 7;
    localparam int VALUE_BITS_DEFAULT = 31;
    localparam int DIV_STEP           = 8;
    localparam int S_TDATA_W          = 40;
    localparam int M_TDATA_W          = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [RADIX_W-1:0] DIGIT_DECIMAL_LIMIT = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  DIGIT_ZERO_CHAR     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  DIGIT_LETTER_OFFSET = CHAR_W'(55);

    typedef struct packed {
        logic done;
        logic quo_zero;
    } t_div_status;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < DIGIT_DECIMAL_LIMIT) begin
            return ext + DIGIT_ZERO_CHAR;
        end
        return ext + DIGIT_LETTER_OFFSET;
    endfunction

endpackage

FILE: rtl/itrd_div_unit.sv
// Shared divider: divides a value by a small radix, several quotient bits a cycle.
// Depends on itrd_pkg.
module itrd_div_unit #(
    parameter int VW = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [VW-1:0]                   i_dividend,
    input  logic [itrd_pkg::RADIX_W-1:0]    i_divisor,
    output logic [VW-1:0]                   o_quotient,
    output logic [itrd_pkg::RADIX_W-1:0]    o_remainder,
    output itrd_pkg::t_div_status           o_status
);

    localparam int STEP  = itrd_pkg::DIV_STEP;
    localparam int NCYC  = (VW + STEP - 1) / STEP;
    localparam int PW    = NCYC * STEP;
    localparam int CNT_W = $clog2(NCYC + 1);
    localparam int RW    = itrd_pkg::RADIX_W;

    logic [PW-1:0]    r_acc, n_acc;
    logic [RW-1:0]    r_rem, n_rem;
    logic [RW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // STEP restoring division steps on a narrow partial remainder.
    always_comb begin
        logic [RW:0] t;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int i = 0; i < STEP; i++) begin
            t     = {n_rem, n_acc[PW-1]};
            n_acc = {n_acc[PW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem    = RW'(t - {1'b0, r_div});
                n_acc[0] = 1'b1;
            end else begin
                n_rem = t[RW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NCYC);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= PW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_quotient        = r_acc[VW-1:0];
    assign o_remainder       = r_rem;
    assign o_status.done     = r_done;
    assign o_status.quo_zero = (r_acc[VW-1:0] == '0);

endmodule

FILE: rtl/itrd_digit_stack.sv
// Last-in first-out store of digit values, presented as ASCII at the top.
// Depends on itrd_pkg.
module itrd_digit_stack #(
    parameter int VW = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [itrd_pkg::RADIX_W-1:0]    i_push_digit,
    input  logic                            i_pop,
    output logic [itrd_pkg::CHAR_W-1:0]     o_top_char,
    output logic [$clog2(VW+1)-1:0]         o_count
);

    localparam int CNT_W = $clog2(VW + 1);
    localparam int IDX_W = $clog2(VW);

    logic [itrd_pkg::RADIX_W-1:0] r_mem [VW];
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             top_pos;

    assign top_pos = r_count - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_pop) begin
            r_count <= top_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_push_digit;
        end
    end

    assign o_top_char = itrd_pkg::digit_to_ascii(r_mem[top_pos[IDX_W-1:0]]);
    assign o_count    = r_count;

endmodule

FILE: rtl/integer_to_radix_digits_core.sv
// Top level of the integer to radix digits core: sequencer and output register.
// Depends on itrd_pkg, itrd_div_unit and itrd_digit_stack.
//
//  Channel   Dir  tdata bits (low to high)           Side band
//  s_axis    in   radix[5:0], value[36:6], zero pad   none
//  m_axis    out  digit_char[6:0], zero pad           tlast = last digit of the run
//
// Each beat in is divided repeatedly by its radix in a shared divider that resolves
// eight quotient bits a cycle; a finished division pushes its remainder onto the stack
// and restarts the divider on the quotient while that is nonzero. The remainders are
// stacked and then sent most significant first, one per cycle when the sink is ready.
// The input is ready only while the sequencer is idle, so a new beat is taken only once
// the last digit of the previous one has left the stack. Reset is synchronous and clears
// the sequencer, the divider control and the stack fill count; a stalled sink simply
// holds the output register and the sequencer waits in the emission phase.
module integer_to_radix_digits_core #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [itrd_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // radix[5:0], value[36:6]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [itrd_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // digit_char[6:0]
    output logic                             o_m_axis_tlast
);

    localparam int RW    = itrd_pkg::RADIX_W;
    localparam int CW    = itrd_pkg::CHAR_W;
    // Value bits at or above VALUE_BITS are ignored, and the field is 31 bits wide.
    localparam int VW    = (VALUE_BITS < itrd_pkg::VALUE_W) ? VALUE_BITS : itrd_pkg::VALUE_W;
    localparam int CNT_W = $clog2(VW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_radix;
    logic          r_m_valid;
    logic [CW-1:0] r_digit;
    logic          r_last;

    logic                  s_accept;
    logic [RW-1:0]         radix_in;
    logic [RW-1:0]         radix_clamped;
    logic [VW-1:0]         value_in;
    logic                  div_start;
    logic [VW-1:0]         div_dividend;
    logic [VW-1:0]         div_quotient;
    logic [RW-1:0]         div_remainder;
    itrd_pkg::t_div_status div_status;
    logic                  push;
    logic                  pop;
    logic [CW-1:0]         top_char;
    logic [CNT_W-1:0]      stack_count;
    logic                  out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign radix_in = i_s_axis_tdata[RW-1:0];
    assign value_in = i_s_axis_tdata[RW +: VW];

    // Out-of-range radix values are pulled to the nearest legal base.
    always_comb begin
        if (radix_in < itrd_pkg::RADIX_MIN) begin
            radix_clamped = itrd_pkg::RADIX_MIN;
        end else if (radix_in > itrd_pkg::RADIX_MAX) begin
            radix_clamped = itrd_pkg::RADIX_MAX;
        end else begin
            radix_clamped = radix_in;
        end
    end

    // A finished division pushes its remainder; a nonzero quotient is divided again
    // in the same cycle, so the next division starts as the remainder is pushed.
    assign push         = (r_state == ST_DIV) && div_status.done;
    assign div_start    = s_accept || (push && !div_status.quo_zero);
    assign div_dividend = s_accept ? value_in : div_quotient;

    assign out_free = !r_m_valid || i_m_axis_tready;
    assign pop      = (r_state == ST_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done && div_status.quo_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (pop && stack_count == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_radix <= radix_clamped;
        end
        if (pop) begin
            r_digit <= top_char;
            r_last  <= (stack_count == CNT_W'(1));
        end
    end

    itrd_div_unit #(
        .VW (VW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (s_accept ? radix_clamped : r_radix),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder),
        .o_status    (div_status)
    );

    itrd_digit_stack #(
        .VW (VW)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_digit (div_remainder),
        .i_pop        (pop),
        .o_top_char   (top_char),
        .o_count      (stack_count)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = itrd_pkg::M_TDATA_W'(r_digit);
    assign o_m_axis_tlast  = r_last;

    // The divider only reports completion while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.done |-> r_state == ST_DIV)
        else $error("divider finished outside the division phase");

    // Emission never runs on an empty stack.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> stack_count != '0)
        else $error("emission with no stacked digit");

    // A busy item always works with a legal radix.
    a_radix_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |->
            (r_radix >= itrd_pkg::RADIX_MIN && r_radix <= itrd_pkg::RADIX_MAX))
        else $error("radix register out of range");

    // No digit string is longer than the value width.
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> stack_count < CNT_W'(VW))
        else $error("digit stack overflow");

endmodule

FILE: sim/radix_digit_checker.sv
// Checker for the integer to radix digits core: predicts the digit string of every
// accepted input beat and compares each output beat with it.
// Depends on itrd_pkg for field widths and digit constants.
module radix_digit_checker #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    input  logic [itrd_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // radix[5:0], value[36:6]
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [itrd_pkg::M_TDATA_W-1:0]   i_m_axis_tdata,  // digit_char[6:0]
    input  logic                             i_m_axis_tlast,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_values_seen,
    output int                               o_digits_seen
);

    localparam int RW = itrd_pkg::RADIX_W;
    localparam int VW = itrd_pkg::VALUE_W;
    localparam int CW = itrd_pkg::CHAR_W;

    typedef struct packed {
        logic [CW-1:0] digit_char;
        logic          last;
    } t_digit_beat;

    t_digit_beat pending_digits[$];
    int          fail_count  = 0;
    int          values_seen = 0;
    int          digits_seen = 0;

    // Appends the digit string of one value, most significant digit first.
    function automatic void queue_digit_string(input logic [RW-1:0] radix_in,
                                               input logic [VW-1:0] value_in);
        logic [RW-1:0]   base;
        longint unsigned rest;
        logic [RW-1:0]   digits_msd_first[$];
        t_digit_beat     beat;
        logic [RW-1:0]   d;
        base = radix_in;
        if (radix_in < itrd_pkg::RADIX_MIN) begin
            base = itrd_pkg::RADIX_MIN;
        end else if (radix_in > itrd_pkg::RADIX_MAX) begin
            base = itrd_pkg::RADIX_MAX;
        end
        rest = longint'(value_in) & ((64'd1 << VALUE_BITS) - 64'd1);
        // Zero still yields one digit, hence the loop runs at least once.
        do begin
            digits_msd_first.push_front(RW'(rest % base));
            rest = rest / base;
        end while (rest != 0);
        foreach (digits_msd_first[k]) begin
            d = digits_msd_first[k];
            if (d < itrd_pkg::DIGIT_DECIMAL_LIMIT) begin
                beat.digit_char = CW'(d) + itrd_pkg::DIGIT_ZERO_CHAR;
            end else begin
                beat.digit_char = CW'(d) + itrd_pkg::DIGIT_LETTER_OFFSET;
            end
            beat.last = (k == digits_msd_first.size() - 1);
            pending_digits.insert(pending_digits.size(), beat);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("digit check at %0t: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_digit_beat want;
        if (!i_rst_n) begin
            pending_digits.delete();
        end else begin
            // Output side first: a digit leaving now cannot belong to a value entering now.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_digits.size() == 0) begin
                    report_mismatch($sformatf("digit 0x%h arrived with none outstanding",
                                              i_m_axis_tdata[CW-1:0]));
                end else begin
                    want = pending_digits.pop_front();
                    digits_seen++;
                    if (i_m_axis_tdata[CW-1:0] !== want.digit_char) begin
                        report_mismatch($sformatf("digit_char 0x%h, wanted 0x%h",
                                                  i_m_axis_tdata[CW-1:0],
                                                  want.digit_char));
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("tlast %b, wanted %b",
                                                  i_m_axis_tlast, want.last));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                queue_digit_string(i_s_axis_tdata[RW-1:0],
                                   i_s_axis_tdata[RW +: VW]);
                values_seen++;
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= pending_digits.size();
        o_values_seen <= values_seen;
        o_digits_seen <= digits_seen;
    end

endmodule

FILE: sim/integer_to_radix_digits_core_tb.sv
// Testbench top for the integer to radix digits core: drives values and radices,
// stalls both stream sides at random and gives the verdict.
// Depends on itrd_pkg, integer_to_radix_digits_core and radix_digit_checker.
module integer_to_radix_digits_core_tb;

    localparam int     RW                = itrd_pkg::RADIX_W;
    localparam int     VW                = itrd_pkg::VALUE_W;
    localparam int     VALUE_BITS        = itrd_pkg::VALUE_BITS_DEFAULT;
    localparam int     RANDOM_VALUES     = 338;
    // The last stretch of random values runs with both sides always willing.
    localparam int     CALM_TAIL         = 60;
    // Padding after the last predicted digit is out, to cover anything still in flight.
    localparam int     DRAIN_CYCLES      = 200;
    localparam int     OUTSTANDING_LIMIT = 20000;
    localparam longint VALUE_MAX         = (64'd1 << VW) - 64'd1;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [itrd_pkg::S_TDATA_W-1:0] i_s_axis_tdata;  // radix[5:0], value[36:6], zero pad
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [itrd_pkg::M_TDATA_W-1:0] o_m_axis_tdata;  // digit_char[6:0], zero pad
    logic                           o_m_axis_tlast;

    int digit_fails;
    int digits_outstanding;
    int values_seen;
    int digits_seen;

    // Set for the final stretch: no gaps on the source, sink always ready.
    logic calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. Sized from the slowest legal run (31-digit items with every digit stalled for
    // the longest sink hold and the longest source gap) and then taken several times over.
    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    integer_to_radix_digits_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    radix_digit_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (digit_fails),
        .o_pending       (digits_outstanding),
        .o_values_seen   (values_seen),
        .o_digits_seen   (digits_seen)
    );

    // Sink side: mixes random bursts of backpressure with ready stretches, now and then
    // a long one so that whole digit runs leave unstalled.
    initial begin : sink_side
        int hold;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 1) == 0) begin
                i_m_axis_tready <= 1'b1;
                if (calm) begin
                    hold = 1;
                end else if ($urandom_range(0, 5) == 0) begin
                    hold = $urandom_range(60, 200);
                end else begin
                    hold = $urandom_range(1, 24);
                end
            end else begin
                i_m_axis_tready <= 1'b0;
                hold = $urandom_range(1, 16);
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    // Presents one beat and returns at the edge where it is accepted. Valid is left
    // high so that a following call can put the next beat out at that same edge;
    // a random gap lowers it first.
    task automatic send_value(input logic [RW-1:0] radix,
                              input logic [VW-1:0] value);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(itrd_pkg::S_TDATA_W - RW - VW){1'b0}}, value, radix};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [RW-1:0] radix_pick;
        logic [VW-1:0] value_pick;
        int            base;
        longint        power;
        int            waited;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero in the smallest, a middle and the largest radix: one digit '0'.
        send_value(6'd2, '0);
        send_value(6'd10, '0);
        send_value(6'd36, '0);
        // Full-scale value: the longest strings, 31 digits in radix 2.
        send_value(6'd2, VW'(VALUE_MAX));
        send_value(6'd10, VW'(VALUE_MAX));
        send_value(6'd16, VW'(VALUE_MAX));
        send_value(6'd36, VW'(VALUE_MAX));
        // Radix below range behaves as radix 2, above range as radix 36.
        send_value(6'd0, VW'(100));
        send_value(6'd1, VW'(5));
        send_value(6'd0, VW'(VALUE_MAX));
        send_value(6'd37, VW'(35));
        send_value(6'd63, VW'(1295));
        send_value(6'd63, VW'(VALUE_MAX));
        // Values just below and at a power of the radix: the digit count grows by one.
        send_value(6'd10, VW'(9));
        send_value(6'd10, VW'(10));
        send_value(6'd36, VW'(35));
        send_value(6'd36, VW'(36));
        send_value(6'd16, VW'(255));
        send_value(6'd16, VW'(256));
        send_value(6'd7, VW'(1));
        send_value(6'd35, VW'(34));
        // Alternating bit patterns so each value bit is seen both ways mid-range.
        send_value(6'd8, VW'(32'h2AAA_AAAA));
        send_value(6'd3, VW'(32'h5555_5555));
        send_value(6'd36, VW'(VALUE_MAX - 1));

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            if (n == RANDOM_VALUES - CALM_TAIL) begin
                calm = 1'b1;
            end
            // Mostly legal radices, with a share of clamped ones at both ends.
            case ($urandom_range(0, 11))
                0:       radix_pick = RW'($urandom_range(0, 1));
                1:       radix_pick = RW'($urandom_range(37, 63));
                default: radix_pick = RW'($urandom_range(2, 36));
            endcase
            base = (radix_pick < itrd_pkg::RADIX_MIN) ? int'(itrd_pkg::RADIX_MIN) :
                   (radix_pick > itrd_pkg::RADIX_MAX) ? int'(itrd_pkg::RADIX_MAX) :
                   int'(radix_pick);
            // Value shapes: full range, random length, a few digits, or next to a
            // power of the radix where the digit count changes.
            case ($urandom_range(0, 3))
                0: value_pick = VW'($urandom);
                1: value_pick = VW'($urandom >> $urandom_range(1, 31));
                2: value_pick = VW'($urandom_range(0, base * base));
                default: begin
                    power = 1;
                    repeat ($urandom_range(1, 30)) begin
                        if (power * base <= VALUE_MAX) begin
                            power = power * base;
                        end
                    end
                    power = power + longint'($urandom_range(0, 2)) - 1;
                    if (power > VALUE_MAX) begin
                        power = VALUE_MAX;
                    end
                    value_pick = VW'(power);
                end
            endcase
            send_value(radix_pick, value_pick);
        end
        i_s_axis_tvalid <= 1'b0;

        // Wait for the checker to take in the last beat, then wait for the digits.
        @(posedge i_clk);
        waited = 0;
        while (digits_outstanding != 0 && waited < OUTSTANDING_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (digits_outstanding != 0) begin
            $display("%0d predicted digits never came out", digits_outstanding);
        end
        $display("Converted %0d values, radices 0 to 63 with clamping, zero and full scale.",
                 values_seen);
        $display("Compared %0d digit beats and their tlast under random stalls on both sides.",
                 digits_seen);
        if (digit_fails == 0 && digits_outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
